/* sv/binomial_coefficient_assert.svh */
// Assertion macros for the binomial coefficient block.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef BINOMIAL_COEFFICIENT_ASSERT_SVH
`define BINOMIAL_COEFFICIENT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("binomial_coefficient: same-cycle check failed");
`define BC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("binomial_coefficient: next-cycle check failed");
`else
`define BC_ASSERT_SAME(label, ante, cons)
`define BC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* sv/bc_pkg.sv */
// Shared widths, constants and control types for the binomial coefficient block.
// No dependencies; every other file but the assertion header imports it.
package bc_pkg;

    localparam int N_W       = 7;
    localparam int COMB_W    = 60;
    localparam int ACC_W     = 64;
    localparam int MULT_W    = 7;
    localparam int PROD_W    = ACC_W + MULT_W;
    localparam int CNT_W     = $clog2(PROD_W);
    localparam int I_W       = 6;
    localparam int MAX_N_DEF = 63;

    typedef struct packed {
        logic load;
        logic mul;
        logic div;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic general;
        logic div_last;
        logic step_last;
    } t_dp_sts;

endpackage

/* sv/bc_if.sv */
// Handshake channels of the binomial coefficient block: input and result beats.
// Depends on bc_pkg.
interface bc_in_if import bc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [N_W-1:0]   n_total;
    logic signed [N_W-1:0]   k_chosen;

    modport source (output valid, n_total, k_chosen, input ready);
    modport sink (input valid, n_total, k_chosen, output ready);
endinterface

interface bc_out_if import bc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [COMB_W-1:0]   combinations;
    logic                status;

    modport source (output valid, combinations, status, input ready);
    modport sink (input valid, combinations, status, output ready);
endinterface

/* sv/binomial_coefficient.sv */
// Binomial coefficient block: n choose k with a validity status, one result per beat.
// Input beats carry signed n_total and k_chosen; result beats carry combinations
// and status (0 success, 1 invalid parameters, combinations then 0).
// Both channels use valid/ready; a beat moves when both are high.
// One item is in work at a time: ready is high only while the block is idle.
// For the trivial cases the decoded result goes from CHECK through HOLD into the
// output register; otherwise m = min(k, n-k) steps run before HOLD.
// Each of the m steps is one 64 by 7 bit multiply followed by a division in
// the bit-serial restoring divider.
// The result sits in an output register; the block takes the next input beat as
// soon as a finished result has moved there, even if the receiver stalls.
// A second result waits in the datapath until the output register is free.
// Synchronous active-low reset returns the controller to idle and drops result
// valid; no state carries from one item to the next.
// Depends on bc_pkg, bc_if, bc_ctrl, bc_datapath and the assertion header.
`include "binomial_coefficient_assert.svh"
module binomial_coefficient import bc_pkg::*; #(
    parameter int MAX_N = MAX_N_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bc_in_if.sink       i_in,
    bc_out_if.source    o_out
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    bc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bc_datapath #(
        .MAX_N (MAX_N)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_n_total      (i_in.n_total),
        .i_k_chosen     (i_in.k_chosen),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_combinations (o_out.combinations),
        .o_status       (o_out.status)
    );

    `BC_ASSERT_SAME(a_invalid_zero, o_out.valid && o_out.status, o_out.combinations == '0)
    `BC_ASSERT_NEXT(a_one_in_flight, i_in.valid && i_in.ready, !i_in.ready)
    `BC_ASSERT_SAME(a_cmd_exclusive, 1'b1, $onehot0({cmd.load, cmd.mul, cmd.div, cmd.emit}))

endmodule

/* sv/bc_datapath.sv */
// Datapath: input decode, accumulator, multiplier and bit-serial restoring divider.
// Depends on bc_pkg; driven by bc_ctrl through t_dp_cmd.
module bc_datapath import bc_pkg::*; #(
    parameter int MAX_N = MAX_N_DEF
) (
    input  logic                    i_clk,
    input  logic signed [N_W-1:0]   i_n_total,
    input  logic signed [N_W-1:0]   i_k_chosen,
    input  t_dp_cmd                 i_cmd,
    output t_dp_sts                 o_sts,
    output logic [COMB_W-1:0]       o_combinations,
    output logic                    o_status
);

    logic [ACC_W-1:0]   r_acc, n_acc;
    logic               r_status, n_status;
    logic               r_general, n_general;
    logic [I_W-1:0]     r_kk, n_kk;
    logic [MULT_W-1:0]  r_base, n_base;
    logic [I_W-1:0]     r_i;
    logic [PROD_W-1:0]  r_prod, n_prod;
    logic [I_W-1:0]     r_rem, n_rem;
    logic [CNT_W-1:0]   r_cnt;
    logic [COMB_W-1:0]  r_comb;
    logic               r_out_status;

    logic [N_W-1:0]     n_u;
    logic [N_W-1:0]     k_u;
    logic [N_W-1:0]     diff;
    logic [N_W-1:0]     kk_full;
    logic [I_W:0]       trial;
    logic               qbit;
    logic [MULT_W-1:0]  factor;

    always_comb begin
        n_u      = unsigned'(i_n_total);
        k_u      = unsigned'(i_k_chosen);
        diff     = n_u - k_u;
        kk_full  = (k_u > diff) ? diff : k_u;
        n_acc    = {{(ACC_W-1){1'b0}}, 1'b1};
        n_status = 1'b0;
        n_general = 1'b0;
        if (n_u == '0 && k_u == '0) begin
            n_acc    = '0;
            n_status = 1'b1;
        end else if (i_n_total[N_W-1] || i_k_chosen[N_W-1]) begin
            n_acc    = '0;
            n_status = 1'b1;
        end else if ({1'b0, n_u} > (N_W+1)'(MAX_N)) begin
            n_acc    = '0;
            n_status = 1'b1;
        end else if (k_u == '0 || n_u == '0 || n_u <= k_u) begin
            n_acc = {{(ACC_W-1){1'b0}}, 1'b1};
        end else if (k_u == N_W'(1)) begin
            n_acc = {{(ACC_W-N_W){1'b0}}, n_u};
        end else begin
            n_general = 1'b1;
        end
        n_kk   = kk_full[I_W-1:0];
        n_base = n_u - kk_full;
    end

    always_comb begin
        factor = r_base + {{(MULT_W-I_W){1'b0}}, r_i};
        trial  = {r_rem, r_prod[PROD_W-1]};
        qbit   = (trial >= {1'b0, r_i});
        n_rem  = qbit ? I_W'(trial - {1'b0, r_i}) : trial[I_W-1:0];
        n_prod = {r_prod[PROD_W-2:0], qbit};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_acc     <= n_acc;
            r_status  <= n_status;
            r_general <= n_general;
            r_kk      <= n_kk;
            r_base    <= n_base;
            r_i       <= {{(I_W-1){1'b0}}, 1'b1};
        end
        if (i_cmd.mul) begin
            r_prod <= {{MULT_W{1'b0}}, r_acc} * {{ACC_W{1'b0}}, factor};
            r_rem  <= '0;
            r_cnt  <= '0;
        end
        if (i_cmd.div) begin
            r_prod <= n_prod;
            r_rem  <= n_rem;
            r_cnt  <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(PROD_W-1)) begin
                r_acc <= n_prod[ACC_W-1:0];
                r_i   <= r_i + I_W'(1);
            end
        end
        if (i_cmd.emit) begin
            r_comb       <= r_acc[COMB_W-1:0];
            r_out_status <= r_status;
        end
    end

    assign o_sts.general   = r_general;
    assign o_sts.div_last  = (r_cnt == CNT_W'(PROD_W-1));
    assign o_sts.step_last = (r_i == r_kk);
    assign o_combinations  = r_comb;
    assign o_status        = r_out_status;

endmodule

/* sv/bc_ctrl.sv */
// Controller state machine: sequences decode, multiply, divide and result hand-off.
// Depends on bc_pkg; commands bc_datapath through t_dp_cmd.
module bc_ctrl import bc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_sts  i_sts,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_DIV,
        S_HOLD
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_sts.general ? S_MUL : S_HOLD;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                if (i_sts.div_last) begin
                    n_state = i_sts.step_last ? S_HOLD : S_MUL;
                end
            end
            S_HOLD: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* verif/tb_binomial_coefficient.sv */
// Self-checking testbench for binomial_coefficient: directed and random (n, k) beats,
// random idling on both channels, and a long result stall to back up the input.
// Depends on bc_pkg and the bc_in_if/bc_out_if channels of the RTL.
module tb_binomial_coefficient;
    import bc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 250;
    localparam int QUIET_TAIL   = 40;
    localparam int LONG_HOLD    = 3000;
    localparam int HOLD_AFTER   = 40;
    localparam int NUM_DIRECTED = 22;
    localparam int DIR_N [NUM_DIRECTED] = '{0, 0, -64, -1, -64, 63, 63, 0, 3, 5, 63,
                                            63, 2, 3, 63, 63, 63, 63, 10, 62, 41, 1};
    localparam int DIR_K [NUM_DIRECTED] = '{0, -64, 0, -1, 63, -1, 63, 5, 10, 0, 0,
                                            1, 1, 2, 2, 62, 31, 32, 5, 31, 20, 1};

    class bc_scoreboard;
        typedef struct {
            int              n;
            int              k;
            logic [COMB_W-1:0] comb;
            logic            status;
        } t_expect;

        bit [63:0] pascal [0:63][0:63];
        t_expect   pending [$];
        int        failures;
        int        checked;

        function new();
            for (int r = 0; r < 64; r++) begin
                pascal[r][0] = 64'd1;
                for (int c = 1; c < 64; c++) begin
                    pascal[r][c] = (r == 0) ? 64'd0 : pascal[r-1][c-1] + pascal[r-1][c];
                end
            end
            failures = 0;
            checked  = 0;
        endfunction

        function void note_input(logic signed [N_W-1:0] n, logic signed [N_W-1:0] k);
            t_expect e;
            e.n      = n;
            e.k      = k;
            e.comb   = '0;
            e.status = 1'b0;
            if (e.n == 0 && e.k == 0) begin
                e.status = 1'b1;
            end else if (e.n < 0 || e.k < 0) begin
                e.status = 1'b1;
            end else if (e.n > MAX_N_DEF) begin
                e.status = 1'b1;
            end else if (e.k == 0 || e.n == 0 || e.n <= e.k) begin
                e.comb = COMB_W'(1);
            end else if (e.k == 1) begin
                e.comb = COMB_W'(e.n);
            end else begin
                e.comb = pascal[e.n][e.k][COMB_W-1:0];
            end
            pending.push_back(e);
        endfunction

        function void check_result(logic [COMB_W-1:0] comb, logic status);
            t_expect e;
            checked++;
            if (pending.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result beat: comb=%0d status=%0b", comb, status);
                return;
            end
            e = pending.pop_front();
            if (comb !== e.comb || status !== e.status) begin
                failures++;
                if (failures <= 10)
                    $display("mismatch n=%0d k=%0d: expected comb=%0d status=%0b, got comb=%0d status=%0b",
                             e.n, e.k, e.comb, e.status, comb, status);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   quiet;
    bc_scoreboard sb;

    bc_in_if  in_ch ();
    bc_out_if out_ch ();

    binomial_coefficient u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    task automatic send_item(input logic signed [N_W-1:0] n, input logic signed [N_W-1:0] k);
        in_ch.valid    <= 1'b1;
        in_ch.n_total  <= n;
        in_ch.k_chosen <= k;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_input(n, k);
    endtask

    task automatic pause_input(input int cycles);
        in_ch.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic maybe_pause();
        if (!quiet && $urandom_range(0, 3) == 0)
            pause_input($urandom_range(1, 14));
    endtask

    initial begin
        logic signed [N_W-1:0] n;
        logic signed [N_W-1:0] k;
        sb = new();
        quiet          = 1'b0;
        i_rst_n        <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.n_total  <= '0;
        in_ch.k_chosen <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            send_item(N_W'(DIR_N[i]), N_W'(DIR_K[i]));
            maybe_pause();
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i >= RANDOM_ITEMS - QUIET_TAIL)
                quiet = 1'b1;
            if ($urandom_range(0, 9) < 6) begin
                n = N_W'($urandom_range(2, 63));
                k = N_W'($urandom_range(0, n));
            end else begin
                n = N_W'($urandom_range(0, 127));
                k = N_W'($urandom_range(0, 127));
            end
            send_item(n, k);
            maybe_pause();
        end
        in_ch.valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (sb.failures == 0 && sb.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Result side: checks each beat and paces ready, including one long hold.
    initial begin
        int  stall_left;
        int  hold_left;
        bit  hold_done;
        stall_left   = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
                sb.check_result(out_ch.combinations, out_ch.status);
            if (!hold_done && sb.checked >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 14) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
